@@ hw/rtl/bch_pkg.sv @@
`default_nettype none

package bch_pkg;

   // Fixed field widths
   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned BIN_WIDTH   = 12;
   localparam int unsigned LIMIT_WIDTH = 31;
   localparam int unsigned SKIP_WIDTH  = 6;

   // bx words above this value carry it as an offset
   localparam logic [WORD_WIDTH-1:0] BX_OFFSET = 32'hF000_0000;

   // Request opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Position inside a frame
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BX     = 2'd1,
      PH_ORBIT  = 2'd2,
      PH_SKIP   = 2'd3
   } frame_phase_type;

   // Control sequencer around the histogram memory
   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_UPDATE = 2'd2,
      ST_READ   = 2'd3
   } ctl_state_type;

endpackage : bch_pkg

`default_nettype wire

@@ hw/rtl/bch_hist_mem.sv @@
`default_nettype none

// Single-port-write, single-port-read histogram store, registered read data
module bch_hist_mem
   import bch_pkg::*;
#(
   parameter int unsigned DEPTH  = 3566,
   parameter int unsigned ADDR_W = 12
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [WORD_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output logic      [WORD_WIDTH-1:0] rd_data
);

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bch_hist_mem

`default_nettype wire

@@ hw/rtl/bunch_crossing_histogram_unit.sv @@
`default_nettype none

// A read's memory data is registered at its accepting edge, then copied into the response
// register once it is free. Header, orbit and muon pushes are taken back to back; a bx push
// does a memory read, then write-back, and a read waits in its read state while the response
// register waits on rsp_ready. Reset (synchronous) clears control state, then all NUM_BX+2
// bins one per cycle; no request is taken during that sweep. CSR writes are taken outside reset.
module bunch_crossing_histogram_unit
   import bch_pkg::*;
#(
   parameter int unsigned NUM_BX = 3564
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_opcode,
   input  wire logic [WORD_WIDTH-1:0]  req_stream_word,
   input  wire logic [BIN_WIDTH-1:0]   req_read_bin,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [BIN_WIDTH-1:0]   rsp_bin_number,
   output logic      [WORD_WIDTH-1:0]  rsp_bin_count,
   // configuration
   input  wire logic                   csr_wr_en,
   input  wire logic [LIMIT_WIDTH-1:0] csr_wr_data
);

   localparam int unsigned NBINS  = NUM_BX + 2;
   localparam int unsigned ADDR_W = $clog2(NBINS);
   localparam logic [BIN_WIDTH:0]  NBINS_CMP = (BIN_WIDTH+1)'(NBINS);
   localparam logic [ADDR_W-1:0]   LAST_BIN  = ADDR_W'(NBINS - 1);
   localparam logic [ADDR_W-1:0]   OVF_BIN   = ADDR_W'(NUM_BX + 1);
   localparam logic [WORD_WIDTH-1:0] MAX_BX  = WORD_WIDTH'(NUM_BX);

   ctl_state_type          state_ff, state_in;
   frame_phase_type        phase_ff, phase_in;
   logic [SKIP_WIDTH-1:0]  skip_ff, skip_in;
   logic [LIMIT_WIDTH-1:0] taken_ff, taken_in;
   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]      upd_addr_ff, upd_addr_in;
   logic [BIN_WIDTH-1:0]   read_num_ff, read_num_in;
   logic                   read_oob_ff, read_oob_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_WIDTH-1:0]   rsp_num_ff, rsp_num_in;
   logic [WORD_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   push;
   logic                   rd_req;
   logic                   bin_in_range;
   logic [WORD_WIDTH-1:0]  bx_adj;
   logic [ADDR_W-1:0]      bx_bin;
   logic [SKIP_WIDTH-1:0]  skip_dec;
   logic                   hdr_blocked;

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [WORD_WIDTH-1:0]  mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [WORD_WIDTH-1:0]  mem_rd_data;

   // handshake decode
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign push      = accept && (req_opcode == OP_PUSH);
   assign rd_req    = accept && (req_opcode == OP_READ);

   assign bin_in_range = ({1'b0, req_read_bin} < NBINS_CMP);

   // bx to bin: strip offset, then clamp to underflow/overflow bins
   always_comb begin
      bx_adj = (req_stream_word > BX_OFFSET) ? (req_stream_word - BX_OFFSET) : req_stream_word;
      priority if (bx_adj == '0) begin
         bx_bin = '0;
      end else if (bx_adj > MAX_BX) begin
         bx_bin = OVF_BIN;
      end else begin
         bx_bin = bx_adj[ADDR_W-1:0];
      end
   end

   assign skip_dec    = (skip_ff != '0) ? (skip_ff - SKIP_WIDTH'(1)) : skip_ff;
   assign hdr_blocked = (limit_ff != '0) && (taken_ff >= limit_ff);

   // frame parser
   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      taken_in = taken_ff;
      if (push) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (!hdr_blocked) begin
                  if (limit_ff != '0) begin
                     taken_in = taken_ff + LIMIT_WIDTH'(1);
                  end
                  // two words per muon, both counts
                  skip_in  = SKIP_WIDTH'({2'b00, req_stream_word[19:16]}
                                         + {2'b00, req_stream_word[3:0]}) << 1;
                  phase_in = PH_BX;
               end
            end
            PH_BX: begin
               phase_in = PH_ORBIT;
            end
            PH_ORBIT: begin
               phase_in = (skip_ff != '0) ? PH_SKIP : PH_HEADER;
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   // sequencer: clearing sweep, read-modify-write, read to response register
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      upd_addr_in  = upd_addr_ff;
      read_num_in  = read_num_ff;
      read_oob_in  = read_oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_count_in = rsp_count_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = upd_addr_ff;
      mem_wr_data  = mem_rd_data + WORD_WIDTH'(1);
      mem_rd_en    = 1'b0;
      mem_rd_addr  = bx_bin;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_BIN) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (push && (phase_ff == PH_BX)) begin
               mem_rd_en   = 1'b1;
               upd_addr_in = bx_bin;
               state_in    = ST_UPDATE;
            end else if (rd_req) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = bin_in_range ? req_read_bin[ADDR_W-1:0] : '0;
               read_num_in = req_read_bin;
               read_oob_in = !bin_in_range;
               state_in    = ST_READ;
            end
         end
         ST_UPDATE: begin
            mem_wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            // wait for a free response slot; read data holds meanwhile
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = read_num_ff;
               rsp_count_in = read_oob_ff ? '0 : mem_rd_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         phase_ff     <= PH_HEADER;
         skip_ff      <= '0;
         taken_ff     <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      upd_addr_ff  <= upd_addr_in;
      read_num_ff  <= read_num_in;
      read_oob_ff  <= read_oob_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_count_ff <= rsp_count_in;
   end

   bch_hist_mem #(
      .DEPTH  (NBINS),
      .ADDR_W (ADDR_W)
   ) u_hist_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_number = rsp_num_ff;
   assign rsp_bin_count  = rsp_count_ff;

endmodule : bunch_crossing_histogram_unit

`default_nettype wire
